// ===== hw/rtl/websocket_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Concurrent assertion wrappers clocked on clk; WSFD_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WSFD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSFD_ASSERT(lbl, prop, msg)
`define WSFD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Parse phases, opcodes, result kinds and the result record.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASKKEY = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED  = 3'd5
	} phase_t;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;
	localparam logic [6:0] PING_MAX   = 7'd125;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [1:0] kind;
		logic       message_start;
		logic       message_end;
		logic       drop_partial;
	} result_t;

endpackage

// ===== hw/rtl/wsfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer input register
// Registers one received byte; stalls only while the held byte cannot advance.
// ----------------------------------------------------------------------------
module wsfd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== hw/rtl/wsfd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer parser
// Frame header state machine, payload unmasking and result marking.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_s1,
	output logic       res_vld,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [2:0]  left_q, left_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  mphase_q, mphase_d;
	logic [6:0]  ping_q, ping_d;
	logic        frag_q, frag_d;
	logic        start_q, start_d;

	logic        is_data;
	logic        length_done;
	logic        hdr_done;
	logic [63:0] len_new;
	logic [63:0] rem_dec;
	logic        last;
	logic        emit_data;
	logic        emit_pend;
	logic        emit_last;
	logic        emit_has;
	logic [7:0]  emit_byte;
	logic [7:0]  plain;

	assign is_data = (opcode_q == OP_CONT) || (opcode_q == OP_TEXT) ||
		(opcode_q == OP_BINARY);
	assign rem_dec = rem_q - 64'd1;
	assign last    = (rem_dec == 64'd0);
	assign plain   = masked_q ? (byte_s1 ^ key_q[{~mphase_q, 3'b000} +: 8]) : byte_s1;

	always_comb begin
		phase_d     = phase_q;
		fin_d       = fin_q;
		opcode_d    = opcode_q;
		masked_d    = masked_q;
		left_d      = left_q;
		key_d       = key_q;
		rem_d       = rem_q;
		mphase_d    = mphase_q;
		ping_d      = ping_q;
		frag_d      = frag_q;
		start_d     = start_q;
		res_vld     = 1'b0;
		res         = '0;
		length_done = 1'b0;
		hdr_done    = 1'b0;
		len_new     = rem_q;
		emit_data   = 1'b0;
		emit_pend   = start_q;
		emit_last   = 1'b0;
		emit_has    = 1'b0;
		emit_byte   = 8'd0;

		case (phase_q)
			PH_HDR1: begin
				masked_d = byte_s1[7];
				if (byte_s1[6:0] == LEN16_CODE) begin
					left_d  = 3'd1;
					rem_d   = 64'd0;
					phase_d = PH_EXTLEN;
				end else if (byte_s1[6:0] == LEN64_CODE) begin
					left_d  = 3'd7;
					rem_d   = 64'd0;
					phase_d = PH_EXTLEN;
				end else begin
					len_new     = {57'd0, byte_s1[6:0]};
					rem_d       = len_new;
					length_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_new = {rem_q[55:0], byte_s1};
				rem_d   = len_new;
				if (left_q == 3'd0) begin
					length_done = 1'b1;
				end else begin
					left_d = left_q - 3'd1;
				end
			end
			PH_MASKKEY: begin
				key_d = {key_q[23:0], byte_s1};
				if (left_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					left_d = left_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				mphase_d = mphase_q + 2'd1;
				rem_d    = rem_dec;
				if (last) begin
					phase_d = PH_HDR0;
				end
				if (is_data) begin
					emit_data = 1'b1;
					emit_has  = 1'b1;
					emit_byte = plain;
					emit_last = last;
				end else if (opcode_q == OP_PING) begin
					if (ping_q < PING_MAX) begin
						ping_d            = ping_q + 7'd1;
						res_vld           = 1'b1;
						res.out_byte      = plain;
						res.has_byte      = 1'b1;
						res.kind          = KIND_PING;
						res.message_start = (ping_q == 7'd0);
						res.message_end   = last || (ping_d == PING_MAX);
					end
				end else if ((opcode_q == OP_CLOSE) && last) begin
					phase_d  = PH_CLOSED;
					res_vld  = 1'b1;
					res.kind = KIND_CLOSE;
				end
			end
			PH_CLOSED: begin
			end
			default: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
		endcase

		if (length_done) begin
			if (masked_d) begin
				key_d   = 32'd0;
				left_d  = 3'd3;
				phase_d = PH_MASKKEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			mphase_d = 2'd0;
			ping_d   = 7'd0;
			if (len_new != 64'd0) begin
				phase_d = PH_PAYLOAD;
				start_d = 1'b1;
			end else begin
				phase_d = PH_HDR0;
				start_d = 1'b0;
				if (is_data) begin
					emit_data = 1'b1;
					emit_pend = 1'b1;
					emit_last = 1'b1;
				end else if (opcode_q == OP_PING) begin
					res_vld           = 1'b1;
					res.kind          = KIND_PING;
					res.message_start = 1'b1;
					res.message_end   = 1'b1;
				end else if (opcode_q == OP_CLOSE) begin
					phase_d  = PH_CLOSED;
					res_vld  = 1'b1;
					res.kind = KIND_CLOSE;
				end
			end
		end

		if (emit_data) begin
			res_vld      = 1'b1;
			res.out_byte = emit_byte;
			res.has_byte = emit_has;
			res.kind     = KIND_DATA;
			if (emit_pend) begin
				if (opcode_q == OP_CONT) begin
					res.message_start = !frag_q;
				end else begin
					res.message_start = 1'b1;
					res.drop_partial  = frag_q;
				end
				frag_d  = 1'b1;
				start_d = 1'b0;
			end
			if (emit_last && fin_q) begin
				res.message_end = 1'b1;
				frag_d          = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= OP_CONT;
			masked_q <= 1'b0;
			left_q   <= 3'd0;
			key_q    <= 32'd0;
			rem_q    <= 64'd0;
			mphase_q <= 2'd0;
			ping_q   <= 7'd0;
			frag_q   <= 1'b0;
			start_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			left_q   <= left_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			mphase_q <= mphase_d;
			ping_q   <= ping_d;
			frag_q   <= frag_d;
			start_q  <= start_d;
		end
	end

	`WSFD_ASSERT(a_closed_sticks, phase_q == PH_CLOSED |=> phase_q == PH_CLOSED, "closed state left")
	`WSFD_ASSERT(a_ping_bound, ping_q <= PING_MAX, "ping count past limit")
	`WSFD_ASSERT(a_close_clean, res_vld && (res.kind == KIND_CLOSE) |-> !res.has_byte && !res.message_start && !res.message_end && !res.drop_partial, "close event carries data or marks")

endmodule

// ===== hw/rtl/wsfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsfd_out_reg
	import wsfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    advance,
	output result_t res_q
);

	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

	`WSFD_ASSERT(a_drop_only_on_transfer, $fell(out_valid) |-> $past(!out_stall), "result dropped before transfer")

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames one byte at a time and emits payload.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one received byte (in_byte) per
// transfer. Output channel out_valid/out_stall carries zero or one result per
// byte: unmasked payload byte with kind and message marks, ping echo bytes,
// empty-frame markers and the single close event.
// Throughput: one byte per cycle while the output is not stalled. The byte is
// registered in the input register at its transfer, then the header state
// machine and unmask logic load the result into the output register, which
// raises out_valid.
// When the receiver stalls, the held result waits and in_stall rises only
// once a byte is also waiting in the input register; bytes that give no
// result still need the output register free to advance.
// Reset clears both valid flags and returns the parser to the first header
// byte; after a close frame all input is consumed without result until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic [1:0] kind,
	output logic       message_start,
	output logic       message_end,
	output logic       drop_partial
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_vld;
	result_t    res;
	result_t    res_q;

	wsfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	wsfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && res_vld),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.advance   (advance),
		.res_q     (res_q)
	);

	assign out_byte      = res_q.out_byte;
	assign has_byte      = res_q.has_byte;
	assign kind          = res_q.kind;
	assign message_start = res_q.message_start;
	assign message_end   = res_q.message_end;
	assign drop_partial  = res_q.drop_partial;

endmodule

// ===== tb/websocket_frame_deframer_test.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds framed byte streams (short, 16-bit and 64-bit lengths, masked and
// unmasked, data, ping, pong, reserved and close opcodes) through the deframer
// with random gaps and output stalls, and compares every result field by
// field with an in-bench frame parser.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test
	import wsfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] OP_PONG = 4'hA;
	localparam int RANDOM_BYTES = 1900;
	localparam int PRINT_LIMIT = 40;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [1:0] kind;
	logic       message_start;
	logic       message_end;
	logic       drop_partial;

	websocket_frame_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.kind         (kind),
		.message_start(message_start),
		.message_end  (message_end),
		.drop_partial (drop_partial)
	);

	always #4 clk = ~clk;

	// parser state
	phase_t      phase = PH_HDR0;
	logic        cur_fin = 1'b0;
	logic [3:0]  cur_opcode = OP_CONT;
	logic        cur_masked = 1'b0;
	logic [2:0]  hdr_left = 3'd0;
	logic [31:0] mask_key = 32'd0;
	logic [63:0] rem_len = 64'd0;
	logic [1:0]  key_idx = 2'd0;
	logic [6:0]  ping_cnt = 7'd0;
	logic        frag_open = 1'b0;
	logic        first_pending = 1'b0;

	result_t     parsed_results[$];
	logic [7:0]  wire_bytes[$];
	bit          wire_hold[$];
	int          mismatches = 0;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void emit(input logic [7:0] b, input logic has, input logic [1:0] k,
			input logic ms, input logic me, input logic dp);
		result_t r;
		r.out_byte = has ? b : 8'h00;
		r.has_byte = has;
		r.kind = k;
		r.message_start = ms;
		r.message_end = me;
		r.drop_partial = dp;
		parsed_results.insert(parsed_results.size(), r);
	endfunction

	function automatic logic is_data_op();
		return cur_opcode == OP_CONT || cur_opcode == OP_TEXT || cur_opcode == OP_BINARY;
	endfunction

	function automatic void emit_data(input logic [7:0] b, input logic has, input logic last);
		logic ms;
		logic me;
		logic dp;
		ms = 1'b0;
		me = 1'b0;
		dp = 1'b0;
		if (first_pending) begin
			if (cur_opcode == OP_CONT) begin
				ms = !frag_open;
			end else begin
				ms = 1'b1;
				dp = frag_open;
			end
			frag_open = 1'b1;
			first_pending = 1'b0;
		end
		if (last && cur_fin) begin
			me = 1'b1;
			frag_open = 1'b0;
		end
		emit(b, has, KIND_DATA, ms, me, dp);
	endfunction

	function automatic void start_payload();
		key_idx = 2'd0;
		ping_cnt = 7'd0;
		first_pending = 1'b1;
		if (rem_len != 64'd0) begin
			phase = PH_PAYLOAD;
			return;
		end
		phase = PH_HDR0;
		if (is_data_op()) begin
			emit_data(8'h00, 1'b0, 1'b1);
		end else begin
			first_pending = 1'b0;
			if (cur_opcode == OP_PING) begin
				emit(8'h00, 1'b0, KIND_PING, 1'b1, 1'b1, 1'b0);
			end else if (cur_opcode == OP_CLOSE) begin
				phase = PH_CLOSED;
				emit(8'h00, 1'b0, KIND_CLOSE, 1'b0, 1'b0, 1'b0);
			end
		end
	endfunction

	function automatic void length_done();
		if (cur_masked) begin
			mask_key = 32'd0;
			hdr_left = 3'd3;
			phase = PH_MASKKEY;
		end else begin
			start_payload();
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic last;
		logic ms;
		case (phase)
			PH_HDR1: begin
				cur_masked = b[7];
				rem_len = 64'd0;
				if (b[6:0] == LEN16_CODE) begin
					hdr_left = 3'd1;
					phase = PH_EXTLEN;
				end else if (b[6:0] == LEN64_CODE) begin
					hdr_left = 3'd7;
					phase = PH_EXTLEN;
				end else begin
					rem_len = 64'(b[6:0]);
					length_done();
				end
			end
			PH_EXTLEN: begin
				rem_len = {rem_len[55:0], b};
				if (hdr_left == 3'd0)
					length_done();
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_MASKKEY: begin
				mask_key = {mask_key[23:0], b};
				if (hdr_left == 3'd0)
					start_payload();
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_PAYLOAD: begin
				if (cur_masked)
					b = b ^ mask_key[8 * (3 - int'(key_idx)) +: 8];
				key_idx = key_idx + 2'd1;
				rem_len = rem_len - 64'd1;
				last = rem_len == 64'd0;
				if (last)
					phase = PH_HDR0;
				if (is_data_op()) begin
					emit_data(b, 1'b1, last);
				end else if (cur_opcode == OP_PING) begin
					if (ping_cnt < PING_MAX) begin
						ms = ping_cnt == 7'd0;
						ping_cnt = ping_cnt + 7'd1;
						emit(b, 1'b1, KIND_PING, ms, last || ping_cnt == PING_MAX, 1'b0);
					end
				end else if (cur_opcode == OP_CLOSE && last) begin
					phase = PH_CLOSED;
					emit(8'h00, 1'b0, KIND_CLOSE, 1'b0, 1'b0, 1'b0);
				end
			end
			PH_CLOSED: begin
			end
			default: begin
				cur_fin = b[7];
				cur_opcode = b[3:0];
				phase = PH_HDR1;
			end
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit hold);
		wire_bytes.insert(wire_bytes.size(), b);
		wire_hold.insert(wire_hold.size(), hold);
	endtask

	task automatic queue_frame(input logic fin, input logic [3:0] opcode, input logic masked,
			input len_form_t form, input int unsigned len, input logic [31:0] key,
			input bit hold);
		logic [63:0] len64;
		len64 = 64'(len);
		push_byte({fin, 3'($urandom_range(0, 7)), opcode}, hold);
		case (form)
			LEN_SHORT: push_byte({masked, 7'(len)}, 1'b0);
			LEN_EXT16: begin
				push_byte({masked, LEN16_CODE}, 1'b0);
				push_byte(len64[15:8], 1'b0);
				push_byte(len64[7:0], 1'b0);
			end
			default: begin
				push_byte({masked, LEN64_CODE}, 1'b0);
				for (int i = 7; i >= 0; i--)
					push_byte(len64[8 * i +: 8], 1'b0);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				push_byte(key[8 * i +: 8], 1'b0);
		for (int unsigned i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// sender
	int unsigned send_gap = 0;
	bit          send_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(in_byte);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (wire_bytes.size() != 0 &&
						(!wire_hold[0] || parsed_results.size() == 0)) begin
					in_valid <= 1'b1;
					in_byte <= wire_bytes.pop_front();
					void'(wire_hold.pop_front());
					if ($urandom_range(0, 19) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int unsigned hold_cycles = 0;
	bit          recv_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {out_byte, has_byte, kind, message_start, message_end, drop_partial};
				if (parsed_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", got));
				end else begin
					want = parsed_results.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							got.out_byte, want.out_byte));
					if (got.has_byte !== want.has_byte)
						report_mismatch($sformatf("has_byte %b, want %b",
							got.has_byte, want.has_byte));
					if (got.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
					if (got.message_start !== want.message_start)
						report_mismatch($sformatf("message_start %b, want %b",
							got.message_start, want.message_start));
					if (got.message_end !== want.message_end)
						report_mismatch($sformatf("message_end %b, want %b",
							got.message_end, want.message_end));
					if (got.drop_partial !== want.drop_partial)
						report_mismatch($sformatf("drop_partial %b, want %b",
							got.drop_partial, want.drop_partial));
				end
				if ($urandom_range(0, 19) == 0)
					recv_burst = !recv_burst;
				hold_cycles = recv_burst ? 0 : $urandom_range(0, 10);
			end else if (hold_cycles != 0) begin
				hold_cycles--;
			end
			out_stall <= hold_cycles != 0;
		end
	end

	initial begin
		int          sel;
		logic [3:0]  op;
		len_form_t   form;
		int unsigned len;
		bit          paused;
		paused = 1'b0;

		queue_frame(1'b1, OP_TEXT, 1'b0, LEN_SHORT, 1, 32'd0, 1'b0);
		queue_frame(1'b0, OP_BINARY, 1'b1, LEN_SHORT, 2, $urandom, 1'b0);
		// new message over an open fragment, empty, non-minimal 16-bit length
		queue_frame(1'b1, OP_TEXT, 1'b0, LEN_EXT16, 0, 32'd0, 1'b0);
		// orphan continuation, empty, masked with an all-zero key
		queue_frame(1'b1, OP_CONT, 1'b1, LEN_SHORT, 0, 32'd0, 1'b0);
		queue_frame(1'b0, OP_PING, 1'b0, LEN_SHORT, 0, 32'd0, 1'b0);
		queue_frame(1'b1, 4'hF, 1'b1, LEN_EXT64, 1, 32'hFFFF_FFFF, 1'b0);

		while (wire_bytes.size() < RANDOM_BYTES) begin
			sel = $urandom_range(0, 99);
			if (sel < 30)
				op = OP_CONT;
			else if (sel < 55)
				op = OP_TEXT;
			else if (sel < 75)
				op = OP_BINARY;
			else if (sel < 87)
				op = OP_PING;
			else if (sel < 93)
				op = OP_PONG;
			else
				do
					op = 4'($urandom);
				while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				form = LEN_SHORT;
				len = $urandom_range(0, 12);
			end else if (sel < 80) begin
				form = LEN_SHORT;
				len = $urandom_range(0, 125);
			end else if (sel < 90) begin
				form = LEN_EXT16;
				len = $urandom_range(0, 140);
			end else begin
				form = LEN_EXT64;
				len = $urandom_range(0, 30);
			end
			if (op == OP_PING && $urandom_range(0, 3) == 0) begin
				form = LEN_EXT16;
				len = $urandom_range(120, 200);
			end
			queue_frame($urandom_range(0, 3) != 0, op, 1'($urandom_range(0, 1)), form, len,
				$urandom, !paused && wire_bytes.size() > RANDOM_BYTES / 2);
			if (wire_bytes.size() > RANDOM_BYTES / 2)
				paused = 1'b1;
		end

		// close ends parsing; the trailing bytes must be dropped
		queue_frame(1'b1, OP_CLOSE, 1'b1, LEN_SHORT, 2, $urandom, 1'b1);
		push_byte({1'b1, 3'd0, OP_TEXT}, 1'b0);
		push_byte(8'h05, 1'b0);
		for (int i = 0; i < 10; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (wire_bytes.size() != 0 || in_valid)
			@(posedge clk);
		for (int n = 0; n < 2000 && parsed_results.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (parsed_results.size() != 0)
			report_mismatch($sformatf("missing result %h", parsed_results.pop_front()));

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
